[rtl/itda_pkg.sv]
// itda_pkg: shared types and constants for the integer to decimal ASCII converter.
// No dependencies; imported by itda_ctrl, itda_dp, int_to_decimal_ascii and the testbench.
`default_nettype none

package itda_pkg;

	localparam int WORD_BITS = 32;
	localparam int IN_BITS   = 32;
	localparam int STEP_BITS = 4;
	localparam int STEPS     = (WORD_BITS + STEP_BITS - 1) / STEP_BITS;
	localparam int PAD_BITS  = STEPS * STEP_BITS;

	function automatic int max_digits(input int bits);
		longint unsigned m;
		int              n;
		m = ~64'd0 >> (64 - bits);
		n = 0;
		for (int i = 0; i < 24; i++) begin
			if (m != 0) begin
				n++;
				m = m / 10;
			end
		end
		return n;
	endfunction

	localparam int DIGITS = max_digits(WORD_BITS);
	localparam int BCD_BITS = DIGITS * 4;
	localparam int POS_W   = (DIGITS > 1) ? $clog2(DIGITS) : 1;
	localparam int CNT_W   = (STEPS > 1) ? $clog2(STEPS) : 1;

	localparam logic [7:0] ASCII_ZERO  = 8'd48;
	localparam logic [7:0] ASCII_MINUS = 8'd45;

	typedef struct packed {
		logic load;
		logic shift;
		logic locate;
		logic out_sign;
		logic out_digit;
	} dp_cmd_t;

	typedef struct packed {
		logic neg;
		logic at_last;
	} dp_sts_t;

endpackage

`default_nettype wire

[rtl/itda_dp.sv]
// itda_dp: datapath; magnitude register, shift-add-3 BCD converter (four bits a
// cycle), leading-zero locate and character output register. Uses itda_pkg.
`default_nettype none

module itda_dp
	import itda_pkg::*;
(
	input  wire logic                clk,
	input  wire logic [IN_BITS-1:0]  value,
	input  wire logic                mode,
	input  wire dp_cmd_t             cmd,
	output dp_sts_t                  sts,
	output logic [7:0]               character,
	output logic                     last
);

	logic [PAD_BITS-1:0]  bin_q;
	logic [BCD_BITS-1:0]  bcd_q;
	logic                 neg_q;
	logic [POS_W-1:0]     pos_q;
	logic [7:0]           char_q;
	logic                 last_q;

	logic [WORD_BITS-1:0] word;
	logic                 neg;
	logic [WORD_BITS-1:0] mag;
	logic [PAD_BITS-1:0]  bin_nx;
	logic [BCD_BITS-1:0]  bcd_nx;
	logic [POS_W-1:0]     lz;
	logic [3:0]           digit;

	assign word = WORD_BITS'(value);
	assign neg  = !mode && word[WORD_BITS-1];
	assign mag  = neg ? (~word + WORD_BITS'(1)) : word;

	// four dependent double-dabble steps
	always_comb begin
		bin_nx = bin_q;
		bcd_nx = bcd_q;
		for (int s = 0; s < STEP_BITS; s++) begin
			for (int d = 0; d < DIGITS; d++) begin
				if (bcd_nx[d*4 +: 4] >= 4'd5)
					bcd_nx[d*4 +: 4] = bcd_nx[d*4 +: 4] + 4'd3;
			end
			bcd_nx = {bcd_nx[BCD_BITS-2:0], bin_nx[PAD_BITS-1]};
			bin_nx = {bin_nx[PAD_BITS-2:0], 1'b0};
		end
	end

	// first nonzero digit, counted from the most significant; last digit if all zero
	always_comb begin
		lz = POS_W'(DIGITS - 1);
		for (int p = DIGITS - 1; p >= 0; p--) begin
			if (bcd_q[(DIGITS-1-p)*4 +: 4] != 4'd0)
				lz = POS_W'(p);
		end
	end

	always_comb begin
		digit = 4'd0;
		for (int p = 0; p < DIGITS; p++) begin
			if (pos_q == POS_W'(p))
				digit = bcd_q[(DIGITS-1-p)*4 +: 4];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bin_q <= PAD_BITS'(mag);
			bcd_q <= '0;
			neg_q <= neg;
		end else if (cmd.shift) begin
			bin_q <= bin_nx;
			bcd_q <= bcd_nx;
		end
		if (cmd.locate)
			pos_q <= lz;
		else if (cmd.out_digit)
			pos_q <= pos_q + POS_W'(1);
		if (cmd.out_sign) begin
			char_q <= ASCII_MINUS;
			last_q <= 1'b0;
		end else if (cmd.out_digit) begin
			char_q <= ASCII_ZERO + {4'd0, digit};
			last_q <= sts.at_last;
		end
	end

	assign sts.neg     = neg_q;
	assign sts.at_last = (pos_q == POS_W'(DIGITS - 1));
	assign character   = char_q;
	assign last        = last_q;

endmodule

`default_nettype wire

[rtl/itda_ctrl.sv]
// itda_ctrl: sequencer for load, conversion steps, locate, sign and digit output.
// Uses itda_pkg; drives itda_dp through dp_cmd_t.
`default_nettype none

module itda_ctrl
	import itda_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    start,
	input  wire dp_sts_t sts,
	output dp_cmd_t      cmd,
	output logic         busy,
	output logic         strobe
);

	typedef enum logic [2:0] {
		IDLE,
		CONV,
		PREP,
		SIGN,
		EMIT
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             strobe_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= IDLE;
			cnt_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				IDLE: begin
					if (start) begin
						cnt_q   <= '0;
						state_q <= CONV;
					end
				end
				CONV: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(STEPS - 1))
						state_q <= PREP;
				end
				PREP: begin
					state_q <= sts.neg ? SIGN : EMIT;
				end
				SIGN: begin
					strobe_q <= 1'b1;
					state_q  <= EMIT;
				end
				EMIT: begin
					strobe_q <= 1'b1;
					if (sts.at_last)
						state_q <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	always_comb begin
		cmd           = '0;
		cmd.load      = (state_q == IDLE) && start;
		cmd.shift     = (state_q == CONV);
		cmd.locate    = (state_q == PREP);
		cmd.out_sign  = (state_q == SIGN);
		cmd.out_digit = (state_q == EMIT);
	end

	assign busy   = (state_q != IDLE);
	assign strobe = strobe_q;

endmodule

`default_nettype wire

[rtl/int_to_decimal_ascii.sv]
// int_to_decimal_ascii: one word in, its decimal text out one character a cycle.
// Sequence: load at the accepting edge, conversion steps (shift-add-3, four bits a cycle), a locate
// step, then one character per cycle; busy until the last one, and no new word is taken before.
// Output is a one-cycle strobe; the receiver cannot stall. arst_n clears control only.
`default_nettype none

module int_to_decimal_ascii
	import itda_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [IN_BITS-1:0] value,
	input  wire logic               mode,
	output logic                    strobe,
	output logic [7:0]              character,
	output logic                    last
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	itda_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.strobe (strobe)
	);

	itda_dp u_dp (
		.clk       (clk),
		.value     (value),
		.mode      (mode),
		.cmd       (cmd),
		.sts       (sts),
		.character (character),
		.last      (last)
	);

endmodule

`default_nettype wire

[bench/testbench.sv]
// testbench: self-checking bench for int_to_decimal_ascii, words in, decimal characters out.
// Depends on rtl/itda_pkg.sv and rtl/int_to_decimal_ascii.sv; a class predicts each character.
`default_nettype none

module testbench;
	import itda_pkg::*;

	typedef struct packed {
		logic [7:0] ch;
		logic       fin;
	} text_char_t;

	class digit_scoreboard;
		text_char_t pending[$];
		int         errors = 0;

		task flag_mismatch(input string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		// expand one accepted word into its expected characters
		function void note_word(input logic [IN_BITS-1:0] v, input logic m);
			logic [63:0] mask;
			logic [63:0] mag;
			logic [7:0]  rev[$];
			logic        neg;
			mask = ~64'd0 >> (64 - WORD_BITS);
			mag = 64'(v) & mask;
			neg = !m && mag[WORD_BITS-1];
			if (neg) begin
				mag = (~mag + 64'd1) & mask;
			end
			do begin
				rev.push_back(ASCII_ZERO + 8'(mag % 64'd10));
				mag = mag / 64'd10;
			end while (mag != 0);
			if (neg) begin
				pending.push_back('{ch: ASCII_MINUS, fin: 1'b0});
			end
			for (int k = rev.size() - 1; k >= 0; k--) begin
				pending.push_back('{ch: rev[k], fin: (k == 0)});
			end
		endfunction

		task check_char(input logic [7:0] c, input logic l);
			text_char_t want;
			if (pending.size() == 0) begin
				flag_mismatch($sformatf("unexpected character 0x%02h last %b", c, l));
			end else begin
				want = pending.pop_front();
				if (c !== want.ch) begin
					flag_mismatch($sformatf("character 0x%02h, want 0x%02h", c, want.ch));
				end
				if (l !== want.fin) begin
					flag_mismatch($sformatf("last %b, want %b (char 0x%02h)", l, want.fin,
						want.ch));
				end
			end
		endtask
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [IN_BITS-1:0] value;
	logic               mode;
	logic               strobe;
	logic [7:0]         character;
	logic               last;

	digit_scoreboard sb = new();

	int_to_decimal_ascii DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.value     (value),
		.mode      (mode),
		.strobe    (strobe),
		.character (character),
		.last      (last)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && strobe) begin
			sb.check_char(character, last);
		end
	end

	// called at a falling edge; returns at the falling edge after the word is taken
	task automatic send_word(input logic [IN_BITS-1:0] v, input logic m, input int gap);
		if (gap > 0) begin
			start = 1'b0;
			value = $urandom;
			mode = 1'($urandom);
			repeat (gap) @(negedge clk);
		end
		start = 1'b1;
		value = v;
		mode = m;
		do @(posedge clk); while (busy);
		sb.note_word(v, m);
		@(negedge clk);
	endtask

	function automatic int pick_gap(input bit quiet);
		if (quiet || $urandom_range(0, 2) != 0) begin
			return 0;
		end
		return $urandom_range(1, 9);
	endfunction

	function automatic logic [IN_BITS-1:0] random_word();
		logic [IN_BITS-1:0] p;
		case ($urandom_range(0, 4))
			0: return IN_BITS'($urandom_range(0, 999));
			1: begin
				p = 1;
				repeat ($urandom_range(0, 9)) p = p * 10;
				return p + IN_BITS'($urandom_range(0, 2)) - 1;
			end
			2: return ((IN_BITS'(1) << (IN_BITS - 1)) + IN_BITS'($urandom_range(0, 15))) ^
				($urandom_range(0, 1) ? '1 : '0);
			default: return $urandom;
		endcase
	endfunction

	initial begin
		logic [IN_BITS-1:0] directed[$];
		start = 1'b0;
		value = '0;
		mode = 1'b0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		directed = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'h7FFFFFFF,
			32'h80000000, 32'hFFFFFFFF, 32'hFFFFFFF6, 32'd999999999, 32'd1000000000,
			32'hAAAAAAAA, 32'h55555555};
		foreach (directed[i]) begin
			send_word(directed[i], 1'b0, pick_gap(0));
			send_word(directed[i], 1'b1, pick_gap(0));
		end

		for (int n = 0; n < 200; n++) begin
			send_word(random_word(), 1'($urandom), pick_gap(n >= 160));
		end
		start = 1'b0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (sb.errors == 0) begin
			$display("** int_to_decimal_ascii: PASSED **");
		end else begin
			$display("** int_to_decimal_ascii: FAILED **");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("** int_to_decimal_ascii: FAILED **");
		$finish;
	end

endmodule

`default_nettype wire
